// ----- hdl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Field widths, operation and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int OP_W   = 1;
  localparam int SIZE_W = 20;
  localparam int OFF_W  = 16;
  localparam int STAT_W = 2;
  localparam int ORD_W  = 5;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOOBIG  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PICK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT,
    S_SET_RD,
    S_SET_WR,
    S_TAB_WR,
    S_FREE_TAB,
    S_MRG_RD,
    S_MRG_CHK,
    S_DONE
  } state_t;

endpackage

// ----- hdl/bba_if.sv -----
// ----------------------------------------------------------------------------
// bba_in_if / bba_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::OP_W-1:0]    operation;
  logic [bba_pkg::SIZE_W-1:0]  request_size;
  logic [bba_pkg::OFF_W-1:0]   block_offset;

  modport source (output valid, operation, request_size, block_offset, input ready);
  modport sink   (input valid, operation, request_size, block_offset, output ready);
endinterface

interface bba_out_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::STAT_W-1:0]  status;
  logic [bba_pkg::OFF_W-1:0]   granted_offset;
  logic [bba_pkg::ORD_W-1:0]   granted_order;

  modport source (output valid, status, granted_offset, granted_order, input ready);
  modport sink   (input valid, status, granted_offset, granted_order, output ready);
endinterface

// ----- hdl/buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// buddy_block_allocator: binary buddy allocator over one pool
// Searches, splits and merges blocks held in a word-organized free bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transfer: operation selects allocate or
//   free, request_size is the byte count of an allocate, block_offset the
//   start of a block to free. out_ch returns exactly one result per request:
//   status, the granted offset and the order of the resulting block.
// Sequencing: an allocate picks a level, then reads and checks free-bitmap
//   words until a free block turns up, then splits it one level at a time
//   (a bitmap read and write of the upper buddy per level) and writes the
//   order table; a free reads the order table, then reads and absorbs free
//   buddies one level up at a time and sets the merged block free. The
//   bitmap port (one word access per cycle) sets the pace. One request is
//   in work at a time; in_ch.ready is high only while the sequencer is idle,
//   and the next request can transfer the cycle after a result is registered.
// Reset: after rst_n the block runs a clearing pass of 2^(MAX_ORDER -
//   MIN_ORDER) cycles (1024 at the defaults) that wipes the order table and
//   sets the free bitmap to a single free whole-pool block. No request is
//   taken during the pass.
// Stalls: a finished result sits in an output register. While out_ch is
//   stalled the block still accepts and works on the next request; it holds
//   that next result internally until the output register frees up.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
  parameter int MIN_ORDER = 6,
  parameter int MAX_ORDER = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bba_in_if.sink     in_ch,
  bba_out_if.source  out_ch
);

  import bba_pkg::*;

  // Tree geometry. Heap index h (root = 1) names a node; depth d has the
  // nodes 2^d .. 2^(d+1)-1, depth 0 is the whole pool at MAX_ORDER.
  localparam int LEVELS = MAX_ORDER - MIN_ORDER + 1;
  localparam int HW     = LEVELS;
  localparam int SLOT_W = LEVELS - 1;
  localparam int SLOTS  = 1 << SLOT_W;
  localparam int WB     = (LEVELS > 5) ? 5 : LEVELS - 1;
  localparam int WORD_W = 1 << WB;
  localparam int WA_W   = LEVELS - WB;
  localparam int NWORDS = 1 << WA_W;
  localparam int DW     = $clog2(LEVELS);
  localparam int CW     = LEVELS;
  localparam int TAB_W  = ORD_W + 1;

  state_t state_r, state_nxt;

  logic [HW-1:0]     h_r, h_nxt;
  logic [HW-1:0]     tgt_r, tgt_nxt;
  logic [DW-1:0]     d_r, d_nxt;
  logic [DW-1:0]     dreq_r, dreq_nxt;
  logic [ORD_W-1:0]  req_r, req_nxt;
  logic [WA_W-1:0]   waddr_r, waddr_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [OP_W-1:0]   mode_r, mode_nxt;
  logic [SLOT_W:0]   init_r, init_nxt;
  logic [CW-1:0]     cnt_r [LEVELS];

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [ORD_W-1:0]  res_ord_r, res_ord_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OFF_W-1:0]  out_off_r;
  logic [ORD_W-1:0]  out_ord_r;

  // Memory ports.
  logic              bm_we;
  logic [WA_W-1:0]   bm_waddr, bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic              tab_we;
  logic [SLOT_W-1:0] tab_waddr, tab_raddr;
  logic [TAB_W-1:0]  tab_wdata, tab_rdata;

  logic cnt_inc, cnt_dec;

  // Decode of the request at the input.
  logic              accept;
  logic [SIZE_W-1:0] size_m1;
  logic [ORD_W-1:0]  size_msb;
  logic              size_big;
  logic [ORD_W-1:0]  in_req;
  logic              in_toobig;
  logic [31:0]       in_off32;
  logic              in_badoff;
  logic [SLOT_W-1:0] in_slot;

  // Search helpers.
  logic              pick_found;
  logic [DW-1:0]     pick_d;
  logic [WORD_W-1:0] lvl_mask;
  logic              scan_hit;
  logic [WB-1:0]     scan_bit;
  logic [HW-1:0]     lvl_bit;
  logic [HW-1:0]     alloc_idx;
  logic [SLOT_W-1:0] alloc_slot;
  logic [DW-1:0]     tab_d;
  logic [HW-1:0]     free_h;
  logic [HW-1:0]     buddy_h;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Rounded order of an allocate: ceil(log2(size)), never below MIN_ORDER.
  always_comb begin
    size_m1  = in_ch.request_size - SIZE_W'(1);
    size_msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size_m1[i]) begin
        size_msb = ORD_W'(i);
      end
    end
    size_big  = {1'b0, in_ch.request_size} > (21'd1 << MIN_ORDER);
    in_req    = size_big ? ORD_W'(size_msb + ORD_W'(1)) : ORD_W'(MIN_ORDER);
    in_toobig = 32'(in_req) > 32'(MAX_ORDER);
    in_off32  = 32'(in_ch.block_offset);
    in_badoff = (in_off32 >= (32'd1 << MAX_ORDER)) ||
                ((in_off32 & ((32'd1 << MIN_ORDER) - 32'd1)) != 32'd0);
    in_slot   = SLOT_W'(in_off32 >> MIN_ORDER);
  end

  // Deepest level at or above the requested order that has a free block.
  always_comb begin
    pick_found = 1'b0;
    pick_d     = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((DW'(i) <= dreq_r) && (cnt_r[i] != '0)) begin
        pick_found = 1'b1;
        pick_d     = DW'(i);
      end
    end
  end

  // Free bits of the current word that belong to level d_r; lowest wins.
  always_comb begin
    scan_hit = 1'b0;
    scan_bit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      lvl_bit     = {waddr_r, WB'(b)};
      lvl_mask[b] = ((lvl_bit >> d_r) == HW'(1)) && bm_rdata[b];
    end
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (lvl_mask[b]) begin
        scan_hit = 1'b1;
        scan_bit = WB'(b);
      end
    end
  end

  always_comb begin
    alloc_idx  = h_r ^ (HW'(1) << d_r);
    alloc_slot = SLOT_W'(alloc_idx << (DW'(LEVELS - 1) - d_r));
    tab_d      = DW'(MAX_ORDER - int'(tab_rdata[ORD_W-1:0]));
    free_h     = (HW'(1) << tab_d) | HW'({1'b0, slot_r} >> (DW'(LEVELS - 1) - tab_d));
    buddy_h    = h_r ^ HW'(1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (init_r == (SLOT_W + 1)'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_ALLOC) begin
            state_nxt = in_toobig ? S_DONE : S_PICK;
          end else begin
            state_nxt = in_badoff ? S_DONE : S_FREE_TAB;
          end
        end
      end
      S_PICK:     state_nxt = pick_found ? S_SCAN_RD : S_DONE;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = scan_hit ? S_SPLIT : S_SCAN_RD;
      S_SPLIT:    state_nxt = (d_r == dreq_r) ? S_TAB_WR : S_SET_RD;
      S_SET_RD:   state_nxt = S_SET_WR;
      S_SET_WR:   state_nxt = (mode_r == OP_ALLOC) ? S_SPLIT : S_DONE;
      S_TAB_WR:   state_nxt = S_DONE;
      S_FREE_TAB: begin
        if (!tab_rdata[TAB_W-1]) begin
          state_nxt = S_DONE;
        end else if (tab_d == '0) begin
          state_nxt = S_SET_RD;
        end else begin
          state_nxt = S_MRG_RD;
        end
      end
      S_MRG_RD: state_nxt = S_MRG_CHK;
      S_MRG_CHK: begin
        if (bm_rdata[buddy_h[WB-1:0]] && (d_r != DW'(1))) begin
          state_nxt = S_MRG_RD;
        end else begin
          state_nxt = S_SET_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates and memory controls.
  always_comb begin
    h_nxt          = h_r;
    tgt_nxt        = tgt_r;
    d_nxt          = d_r;
    dreq_nxt       = dreq_r;
    req_nxt        = req_r;
    waddr_nxt      = waddr_r;
    slot_nxt       = slot_r;
    mode_nxt       = mode_r;
    init_nxt       = init_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_ord_nxt    = res_ord_r;
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    bm_we          = 1'b0;
    bm_waddr       = tgt_r[HW-1:WB];
    bm_wdata       = bm_rdata;
    bm_raddr       = waddr_r;
    tab_we         = 1'b0;
    tab_waddr      = slot_r;
    tab_wdata      = '0;
    tab_raddr      = in_slot;
    case (state_r)
      S_INIT: begin
        // Clearing pass: order table entries, with the bitmap words written alongside
        // the first entries; the first word holds the root node as its only free block.
        tab_we    = 1'b1;
        tab_waddr = init_r[SLOT_W-1:0];
        if (init_r < (SLOT_W + 1)'(NWORDS)) begin
          bm_we    = 1'b1;
          bm_waddr = WA_W'(init_r);
          bm_wdata = (init_r == '0) ? WORD_W'(2) : '0;
        end
        init_nxt = init_r + (SLOT_W + 1)'(1);
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = in_ch.operation;
          req_nxt     = in_req;
          dreq_nxt    = DW'(MAX_ORDER - int'(in_req));
          slot_nxt    = in_slot;
          res_status_nxt = ST_OK;
          res_off_nxt    = '0;
          res_ord_nxt    = '0;
          if (in_ch.operation == OP_ALLOC) begin
            if (in_toobig) begin
              res_status_nxt = ST_TOOBIG;
            end
          end else if (in_badoff) begin
            res_status_nxt = ST_BADFREE;
          end
        end
      end
      S_PICK: begin
        d_nxt     = pick_d;
        waddr_nxt = WA_W'((HW'(1) << pick_d) >> WB);
        if (!pick_found) begin
          res_status_nxt = ST_NOMEM;
        end
      end
      S_SCAN_CHK: begin
        if (scan_hit) begin
          // Take the block: clear its bit in the word just read.
          h_nxt              = {waddr_r, scan_bit};
          bm_we              = 1'b1;
          bm_waddr           = waddr_r;
          bm_wdata           = bm_rdata;
          bm_wdata[scan_bit] = 1'b0;
          cnt_dec            = 1'b1;
        end else begin
          waddr_nxt = waddr_r + WA_W'(1);
        end
      end
      S_SPLIT: begin
        if (d_r != dreq_r) begin
          // Keep the lower half, free the upper buddy.
          h_nxt   = h_r << 1;
          tgt_nxt = (h_r << 1) | HW'(1);
          d_nxt   = d_r + DW'(1);
        end
      end
      S_SET_RD: begin
        bm_raddr = tgt_r[HW-1:WB];
      end
      S_SET_WR: begin
        bm_we                    = 1'b1;
        bm_wdata[tgt_r[WB-1:0]]  = 1'b1;
        cnt_inc                  = 1'b1;
        if (mode_r == OP_FREE) begin
          res_ord_nxt = ORD_W'(MAX_ORDER - int'(d_r));
        end
      end
      S_TAB_WR: begin
        tab_we      = 1'b1;
        tab_waddr   = alloc_slot;
        tab_wdata   = {1'b1, req_r};
        res_off_nxt = OFF_W'(32'(alloc_slot) << MIN_ORDER);
        res_ord_nxt = req_r;
      end
      S_FREE_TAB: begin
        if (!tab_rdata[TAB_W-1]) begin
          res_status_nxt = ST_BADFREE;
        end else begin
          tab_we    = 1'b1;
          tab_wdata = '0;
          h_nxt     = free_h;
          tgt_nxt   = free_h;
          d_nxt     = tab_d;
        end
      end
      S_MRG_RD: begin
        bm_raddr = buddy_h[HW-1:WB];
      end
      S_MRG_CHK: begin
        if (bm_rdata[buddy_h[WB-1:0]]) begin
          // Buddy is free: absorb it and move one level up.
          bm_we                     = 1'b1;
          bm_waddr                  = buddy_h[HW-1:WB];
          bm_wdata[buddy_h[WB-1:0]] = 1'b0;
          cnt_dec                   = 1'b1;
          h_nxt                     = h_r >> 1;
          tgt_nxt                   = h_r >> 1;
          d_nxt                     = d_r - DW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      if (cnt_inc) begin
        cnt_r[d_r] <= cnt_r[d_r] + CW'(1);
      end else if (cnt_dec) begin
        cnt_r[d_r] <= cnt_r[d_r] - CW'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r          <= h_nxt;
    tgt_r        <= tgt_nxt;
    d_r          <= d_nxt;
    dreq_r       <= dreq_nxt;
    req_r        <= req_nxt;
    waddr_r      <= waddr_nxt;
    slot_r       <= slot_nxt;
    mode_r       <= mode_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_ord_r    <= res_ord_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_ord_r    <= res_ord_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.granted_offset = out_off_r;
  assign out_ch.granted_order  = out_ord_r;

  // Free bitmap: one bit per tree node, WORD_W nodes to a word.
  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // Order table: live flag and order of the block starting at each slot.
  bba_ram #(
    .WIDTH (TAB_W),
    .DEPTH (SLOTS)
  ) u_order_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

endmodule

// ----- hdl/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_buddy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator: self-checking bench of the buddy block allocator
// Drives allocate and free requests under several handshake pressure phases,
// predicts each result with a behavioral copy of the allocator tree, and
// compares every result transfer field by field in arrival order.
// ----------------------------------------------------------------------------

// Expected results and the allocator state that produces them.
class buddy_scoreboard;
  localparam int MINO  = 6;
  localparam int MAXO  = 16;
  localparam int NODES = (2 << (MAXO - MINO)) - 1;
  localparam int SLOTS = 1 << (MAXO - MINO);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [4:0]  order;
  } grant_t;

  bit          node_free [NODES];
  logic [4:0]  slot_order [SLOTS];
  bit          slot_live [SLOTS];
  grant_t      pending_grants [$];
  int          errors;
  int          checked;

  function new();
    foreach (node_free[i]) node_free[i] = 0;
    foreach (slot_live[i]) slot_live[i] = 0;
    node_free[0] = 1;
    errors = 0;
    checked = 0;
  endfunction

  function int node_index(int off, int ord);
    return ((1 << (MAXO - ord)) - 1) + (off >> ord);
  endfunction

  function grant_t allocate(logic [19:0] size);
    grant_t g;
    int req;
    int chunk;
    int cur;
    int off;
    g = '{bba_pkg::ST_NOMEM, 16'd0, 5'd0};
    req = MINO;
    chunk = 1 << MINO;
    while (chunk < size && req <= MAXO) begin
      req++;
      chunk = chunk << 1;
    end
    if (req > MAXO) return '{bba_pkg::ST_TOOBIG, 16'd0, 5'd0};
    for (int ord = req; ord <= MAXO; ord++) begin
      for (int i = 0; i < (1 << (MAXO - ord)); i++) begin
        off = i << ord;
        if (node_free[node_index(off, ord)]) begin
          node_free[node_index(off, ord)] = 0;
          cur = ord;
          while (cur > req) begin
            cur--;
            node_free[node_index(off + (1 << cur), cur)] = 1;
          end
          slot_order[off >> MINO] = req[4:0];
          slot_live[off >> MINO] = 1;
          return '{bba_pkg::ST_OK, off[15:0], req[4:0]};
        end
      end
    end
    return g;
  endfunction

  function grant_t release_block(logic [15:0] offset);
    int off;
    int ord;
    int buddy;
    off = offset;
    if (off[MINO-1:0] != 0 || off >= (1 << MAXO) || !slot_live[off >> MINO])
      return '{bba_pkg::ST_BADFREE, 16'd0, 5'd0};
    ord = slot_order[off >> MINO];
    slot_live[off >> MINO] = 0;
    while (ord < MAXO) begin
      buddy = off ^ (1 << ord);
      if (!node_free[node_index(buddy, ord)]) break;
      node_free[node_index(buddy, ord)] = 0;
      if (buddy < off) off = buddy;
      ord++;
    end
    node_free[node_index(off, ord)] = 1;
    return '{bba_pkg::ST_OK, 16'd0, ord[4:0]};
  endfunction

  function void note_request(logic op, logic [19:0] size, logic [15:0] offset);
    if (op == bba_pkg::OP_ALLOC) pending_grants.push_back(allocate(size));
    else pending_grants.push_back(release_block(offset));
  endfunction

  task check_grant(logic [1:0] st, logic [15:0] off, logic [4:0] ord);
    grant_t e;
    checked++;
    if (pending_grants.size() == 0) begin
      report_mismatch("result with nothing expected");
      return;
    end
    e = pending_grants.pop_front();
    if (st !== e.status)
      report_mismatch($sformatf("status got %0d want %0d", st, e.status));
    if (off !== e.offset)
      report_mismatch($sformatf("offset got %h want %h", off, e.offset));
    if (ord !== e.order)
      report_mismatch($sformatf("order got %0d want %0d", ord, e.order));
  endtask

  task report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", checked, msg);
    errors++;
  endtask

  // Offsets of live allocations, for building legal frees.
  function int live_count();
    int n;
    n = 0;
    foreach (slot_live[i]) if (slot_live[i]) n++;
    return n;
  endfunction

  function logic [15:0] pick_live();
    int k;
    k = $urandom_range(live_count() - 1);
    foreach (slot_live[i]) begin
      if (slot_live[i]) begin
        if (k == 0) return 16'(i << MINO);
        k--;
      end
    end
    return 16'd0;
  endfunction
endclass

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  int   sent;

  bba_in_if  req_ch ();
  bba_out_if res_ch ();

  buddy_scoreboard board;

  buddy_block_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; results are checked at the rising edge.
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      board.check_grant(res_ch.status, res_ch.granted_offset, res_ch.granted_order);
  end

  // Watchdog: any cycle without a transfer on either channel counts.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding",
                 board.pending_grants.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Present one request and hold it until the transfer; idle gaps come first.
  // Valid stays high after a transfer until an idle gap or the end of the run.
  task send_request(logic op, logic [19:0] size, logic [15:0] offset);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.request_size <= size;
    req_ch.block_offset <= offset;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(op, size, offset);
    sent++;
    @(negedge clk);
  endtask

  // Mostly legal work with random sizes, plus odd frees and big requests.
  task random_request();
    int pick;
    logic [19:0] size;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: size = 20'($urandom_range(64));
        1: size = 20'($urandom_range(1024));
        2: size = 20'($urandom_range(16384));
        default: size = 20'($urandom);
      endcase
      send_request(OP_ALLOC, size, 16'($urandom));
    end else if (pick < 85 && board.live_count() > 0) begin
      send_request(OP_FREE, 20'($urandom), board.pick_live());
    end else if (pick < 93) begin
      send_request(OP_FREE, 20'($urandom), 16'($urandom) & 16'hFFC0);
    end else begin
      send_request(OP_FREE, 20'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.request_size = '0;
    req_ch.block_offset = '0;
    res_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: size extremes, too large, out of memory, bad and double frees.
    send_request(OP_ALLOC, 20'd0, 16'hFFFF);
    send_request(OP_ALLOC, 20'd1, 16'd0);
    send_request(OP_ALLOC, 20'd65, 16'd0);
    send_request(OP_ALLOC, 20'd65537, 16'd0);
    send_request(OP_ALLOC, 20'hFFFFF, 16'd0);
    send_request(OP_FREE, 20'hFFFFF, 16'd1);
    send_request(OP_FREE, 20'd0, 16'hFFC0);
    send_request(OP_FREE, 20'd0, 16'd64);
    send_request(OP_FREE, 20'd0, 16'd0);
    send_request(OP_FREE, 20'd0, 16'd0);
    send_request(OP_FREE, 20'd0, 16'd128);
    send_request(OP_FREE, 20'd0, 16'd64);
    send_request(OP_ALLOC, 20'd65536, 16'd0);
    send_request(OP_ALLOC, 20'd64, 16'd0);
    send_request(OP_FREE, 20'd0, 16'd0);
    send_request(OP_FREE, 20'd0, 16'd0);
    send_request(OP_ALLOC, 20'd32768, 16'd0);
    send_request(OP_ALLOC, 20'd32768, 16'd0);
    send_request(OP_ALLOC, 20'd1, 16'd0);
    send_request(OP_FREE, 20'd0, 16'h8000);
    send_request(OP_FREE, 20'd0, 16'd0);

    // Random phases under different pressure mixes.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 87 : (phase == 3) ? 13 : 0;
      recv_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 13 : 0;
      repeat (500) random_request();
    end
    req_ch.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    while (board.pending_grants.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d requests and %0d results under four handshake phases.",
             sent, board.checked);
    if (board.errors == 0 && board.pending_grants.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
